FILE: hdl/xorshift64_uniform_draw_unit_assert.svh
`ifndef XORSHIFT64_UNIFORM_DRAW_UNIT_ASSERT_SVH
`define XORSHIFT64_UNIFORM_DRAW_UNIT_ASSERT_SVH

// same-cycle implication
`define XUD_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("xud: assertion failed");

// next-cycle implication
`define XUD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("xud: assertion failed");

`endif

FILE: hdl/xud_pkg.sv
package xud_pkg;

  localparam int unsigned WORD_W = 64;
  localparam int unsigned BOUND_W = 32;
  localparam int unsigned SHIFT_A = 13;
  localparam int unsigned SHIFT_B = 7;
  localparam int unsigned SHIFT_C = 17;
  localparam int unsigned REM_STEPS = WORD_W;
  localparam int unsigned REM_CNT_W = $clog2(REM_STEPS);
  localparam logic [WORD_W-1:0] SEED_RESET = WORD_W'(1);

  localparam int unsigned STEP_W = 4;
  typedef logic [STEP_W-1:0] step_t;

  localparam step_t S_IDLE    = 4'd0;
  localparam step_t S_CHK     = 4'd1;
  localparam step_t S_LIM_LD  = 4'd2;
  localparam step_t S_LIM_RUN = 4'd3;
  localparam step_t S_LIMIT   = 4'd4;
  localparam step_t S_GEN     = 4'd5;
  localparam step_t S_TEST    = 4'd6;
  localparam step_t S_MOD_LD  = 4'd7;
  localparam step_t S_MOD_RUN = 4'd8;
  localparam step_t S_DONE    = 4'd9;
  localparam step_t S_RET     = 4'd10;
  localparam step_t S_ZERO    = 4'd11;

  typedef enum logic [2:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_INPUT,
    C_BOUND_ZERO,
    C_DIV_BUSY,
    C_REJECT,
    C_OUT_BUSY
  } cond_t;

  typedef enum logic [1:0] {
    D_NONE,
    D_ONES,
    D_WORD,
    D_ZERO
  } dsrc_t;

  typedef struct packed {
    dsrc_t div_load;
    logic  div_run;
    logic  limit_ld;
    logic  gen_step;
    logic  emit;
    cond_t cond;
    step_t target;
  } ctl_t;

  typedef struct packed {
    logic load;
    logic run;
  } rem_cmd_t;

  function automatic ctl_t rom_word(step_t pc);
    ctl_t w;
    w = '{div_load: D_NONE, div_run: 1'b0, limit_ld: 1'b0, gen_step: 1'b0,
          emit: 1'b0, cond: C_NEVER, target: S_IDLE};
    case (pc)
      S_IDLE: begin
        w.cond = C_NO_INPUT;
        w.target = S_IDLE;
      end
      S_CHK: begin
        w.cond = C_BOUND_ZERO;
        w.target = S_ZERO;
      end
      S_LIM_LD: begin
        w.div_load = D_ONES;
      end
      S_LIM_RUN: begin
        w.div_run = 1'b1;
        w.cond = C_DIV_BUSY;
        w.target = S_LIM_RUN;
      end
      S_LIMIT: begin
        w.limit_ld = 1'b1;
      end
      S_GEN: begin
        w.gen_step = 1'b1;
      end
      S_TEST: begin
        w.cond = C_REJECT;
        w.target = S_GEN;
      end
      S_MOD_LD: begin
        w.div_load = D_WORD;
      end
      S_MOD_RUN: begin
        w.div_run = 1'b1;
        w.cond = C_DIV_BUSY;
        w.target = S_MOD_RUN;
      end
      S_DONE: begin
        w.emit = 1'b1;
        w.cond = C_OUT_BUSY;
        w.target = S_DONE;
      end
      S_RET: begin
        w.cond = C_ALWAYS;
        w.target = S_IDLE;
      end
      S_ZERO: begin
        w.gen_step = 1'b1;
        w.div_load = D_ZERO;
        w.cond = C_ALWAYS;
        w.target = S_DONE;
      end
      default: begin
        w.cond = C_ALWAYS;
        w.target = S_IDLE;
      end
    endcase
    return w;
  endfunction

  function automatic logic [WORD_W-1:0] xs_step(logic [WORD_W-1:0] s);
    logic [WORD_W-1:0] x;
    x = s;
    x = x ^ (x << SHIFT_A);
    x = x ^ (x >> SHIFT_B);
    x = x ^ (x << SHIFT_C);
    return x;
  endfunction

endpackage

FILE: hdl/xud_rem.sv
module xud_rem (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  xud_pkg::rem_cmd_t                    cmd,
  input  logic [xud_pkg::WORD_W-1:0]           dividend,
  input  logic [xud_pkg::BOUND_W-1:0]          divisor,
  output logic [xud_pkg::BOUND_W-1:0]          rem,
  output logic                                 last
);

  logic [xud_pkg::WORD_W-1:0]    dvd_r;
  logic [xud_pkg::BOUND_W-1:0]   rem_r;
  logic [xud_pkg::REM_CNT_W-1:0] cnt_r;
  logic [xud_pkg::BOUND_W:0]     trial;
  logic [xud_pkg::BOUND_W+1:0]   diff;
  logic [xud_pkg::BOUND_W-1:0]   rem_nxt;

  assign trial = {rem_r, dvd_r[xud_pkg::WORD_W-1]};
  assign diff = {1'b0, trial} - {2'b00, divisor};
  assign rem_nxt = diff[xud_pkg::BOUND_W+1] ? trial[xud_pkg::BOUND_W-1:0]
                                            : diff[xud_pkg::BOUND_W-1:0];
  assign rem = rem_r;
  assign last = (cnt_r == {xud_pkg::REM_CNT_W{1'b1}});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.load) begin
      cnt_r <= '0;
    end else if (cmd.run) begin
      cnt_r <= cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      dvd_r <= dividend;
      rem_r <= '0;
    end else if (cmd.run) begin
      dvd_r <= {dvd_r[xud_pkg::WORD_W-2:0], 1'b0};
      rem_r <= rem_nxt;
    end
  end

endmodule

FILE: hdl/xorshift64_uniform_draw_unit.sv
// Unbiased bounded draws from a 64-bit xorshift generator (shifts 13, 7, 17).
// Each input transaction carries a bound n; the unit derives the rejection
// limit 2^64-1 - ((2^64-1) mod n), steps the generator until a word below it
// appears, and returns that word mod n with the raw word. A write on cfg_we
// loads cfg_data into the generator state; reset loads 1. Both remainders run
// on one shared restoring remainder unit at one bit per cycle; every rejected
// word adds one more generator step and test. After the result is presented the
// unit passes through S_RET back to S_IDLE before it takes the next request.
// A zero bound steps the generator once and returns value 0. One request is in
// flight at a time; a new one is taken while the previous result still waits
// at the output.
module xorshift64_uniform_draw_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [xud_pkg::WORD_W-1:0]    cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [xud_pkg::BOUND_W-1:0]   in_bound,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [xud_pkg::BOUND_W-1:0]   out_value,
  output logic [xud_pkg::WORD_W-1:0]    out_raw_word
);

  xud_pkg::step_t                pc_r;
  xud_pkg::step_t                pc_nxt;
  xud_pkg::ctl_t                 ctl;
  xud_pkg::rem_cmd_t             rem_cmd;
  logic [xud_pkg::WORD_W-1:0]    state_r;
  logic [xud_pkg::WORD_W-1:0]    word_r;
  logic [xud_pkg::WORD_W-1:0]    limit_r;
  logic [xud_pkg::BOUND_W-1:0]   bound_r;
  logic [xud_pkg::WORD_W-1:0]    gen_nxt;
  logic [xud_pkg::WORD_W-1:0]    dividend;
  logic [xud_pkg::BOUND_W-1:0]   rem;
  logic                          rem_last;
  logic                          in_acc;
  logic                          out_busy;
  logic                          take;
  logic                          out_valid_r;
  logic [xud_pkg::BOUND_W-1:0]   out_value_r;
  logic [xud_pkg::WORD_W-1:0]    out_raw_word_r;

  assign ctl = xud_pkg::rom_word(pc_r);
  assign in_stall = (pc_r != xud_pkg::S_IDLE);
  assign in_acc = in_valid && !in_stall;
  assign out_busy = out_valid_r && out_stall;
  assign gen_nxt = xud_pkg::xs_step(state_r);

  assign out_valid = out_valid_r;
  assign out_value = out_value_r;
  assign out_raw_word = out_raw_word_r;

  always_comb begin
    case (ctl.cond)
      xud_pkg::C_NEVER:      take = 1'b0;
      xud_pkg::C_ALWAYS:     take = 1'b1;
      xud_pkg::C_NO_INPUT:   take = !in_valid;
      xud_pkg::C_BOUND_ZERO: take = (bound_r == '0);
      xud_pkg::C_DIV_BUSY:   take = !rem_last;
      xud_pkg::C_REJECT:     take = (word_r >= limit_r);
      xud_pkg::C_OUT_BUSY:   take = out_busy;
      default:               take = 1'b0;
    endcase
    pc_nxt = take ? ctl.target : pc_r + 1'b1;
  end

  always_comb begin
    case (ctl.div_load)
      xud_pkg::D_ONES: dividend = '1;
      xud_pkg::D_WORD: dividend = word_r;
      default:         dividend = '0;
    endcase
    rem_cmd.load = (ctl.div_load != xud_pkg::D_NONE);
    rem_cmd.run = ctl.div_run;
  end

  xud_rem u_rem (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (rem_cmd),
    .dividend (dividend),
    .divisor  (bound_r),
    .rem      (rem),
    .last     (rem_last)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= xud_pkg::S_IDLE;
      out_valid_r <= 1'b0;
      state_r <= xud_pkg::SEED_RESET;
    end else begin
      pc_r <= pc_nxt;
      if (cfg_we) begin
        state_r <= cfg_data;
      end else if (ctl.gen_step) begin
        state_r <= gen_nxt;
      end
      if (ctl.emit && !out_busy) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      bound_r <= in_bound;
    end
    if (ctl.gen_step) begin
      word_r <= gen_nxt;
    end
    if (ctl.limit_ld) begin
      limit_r <= ~{{(xud_pkg::WORD_W-xud_pkg::BOUND_W){1'b0}}, rem};
    end
    if (ctl.emit && !out_busy) begin
      out_value_r <= rem;
      out_raw_word_r <= word_r;
    end
  end

endmodule

FILE: hdl/xud_check.sv
`include "xorshift64_uniform_draw_unit_assert.svh"

module xud_check (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall
);

  `XUD_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)
  `XUD_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)
  `XUD_ASSERT_SAME(a_result_while_busy, $rose(out_valid), in_stall)
  `XUD_ASSERT_NEXT(a_no_instant_result, in_valid && !in_stall, !$rose(out_valid))

endmodule

bind xorshift64_uniform_draw_unit xud_check u_check (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall)
);

FILE: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;

  typedef logic [xud_pkg::WORD_W-1:0] word_t;
  typedef logic [xud_pkg::BOUND_W-1:0] bound_t;

  typedef struct {
    bound_t value;
    word_t  raw_word;
  } draw_t;

  localparam word_t ALL_ONES = '1;

  logic   clk = 1'b0;
  logic   rst_n = 1'b0;
  logic   cfg_we = 1'b0;
  word_t  cfg_data = '0;
  logic   in_valid = 1'b0;
  logic   in_stall;
  bound_t in_bound = '0;
  logic   out_valid;
  logic   out_stall = 1'b0;
  bound_t out_value;
  word_t  out_raw_word;

  word_t gen_state = xud_pkg::SEED_RESET;
  draw_t pending_draws[$];
  int    fault_count = 0;
  bit    pace_on = 1'b1;
  bit    valid_kept = 1'b0;
  int    next_gap = 0;
  int    stall_left = 0;

  xorshift64_uniform_draw_unit DUT (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_bound     (in_bound),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_value    (out_value),
    .out_raw_word (out_raw_word)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic word_t advance(word_t s);
    word_t t;
    t = s ^ (s << xud_pkg::SHIFT_A);
    t = t ^ (t >> xud_pkg::SHIFT_B);
    t = t ^ (t << xud_pkg::SHIFT_C);
    return t;
  endfunction

  function automatic word_t undo_left(word_t y, int unsigned s);
    word_t x;
    x = y;
    for (int unsigned k = s; k < xud_pkg::WORD_W; k += s) x ^= y << k;
    return x;
  endfunction

  function automatic word_t undo_right(word_t y, int unsigned s);
    word_t x;
    x = y;
    for (int unsigned k = s; k < xud_pkg::WORD_W; k += s) x ^= y >> k;
    return x;
  endfunction

  // state whose next word is the given one
  function automatic word_t rewind(word_t w);
    return undo_left(undo_right(undo_left(w, xud_pkg::SHIFT_C), xud_pkg::SHIFT_B),
                     xud_pkg::SHIFT_A);
  endfunction

  function automatic word_t reject_limit(bound_t bound);
    return ALL_ONES - (ALL_ONES % word_t'(bound));
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!pace_on || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic bound_t random_bound();
    bound_t b;
    case ($urandom_range(0, 4))
      0: b = $urandom_range(1, 16);
      1: b = bound_t'(1) << $urandom_range(0, xud_pkg::BOUND_W - 1);
      2: b = ALL_ONES[xud_pkg::BOUND_W-1:0] - $urandom_range(0, 15);
      default: b = $urandom;
    endcase
    if (b == '0) b = 1;
    return b;
  endfunction

  function automatic word_t random_seed();
    word_t s;
    s = {$urandom, $urandom};
    if (s == '0) s = 1;
    return s;
  endfunction

  function automatic void note_fault(string msg);
    fault_count++;
    if (fault_count <= 10) $display("%s", msg);
  endfunction

  task automatic predict_draw(input bound_t bound);
    word_t limit;
    draw_t d;
    limit = reject_limit(bound);
    do gen_state = advance(gen_state); while (gen_state >= limit);
    d.raw_word = gen_state;
    d.value = bound_t'(gen_state % word_t'(bound));
    pending_draws.push_back(d);
  endtask

  task automatic request_draw(input bound_t bound);
    repeat (next_gap) @(posedge clk);
    in_valid <= 1'b1;
    in_bound <= bound;
    do @(posedge clk); while (in_stall);
    predict_draw(bound);
    next_gap = pick_gap();
    valid_kept = (next_gap == 0);
    if (!valid_kept) in_valid <= 1'b0;
  endtask

  task automatic release_input();
    if (valid_kept) begin
      in_valid <= 1'b0;
      valid_kept = 1'b0;
    end
  endtask

  task automatic wait_for_draws();
    release_input();
    while (pending_draws.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic load_seed(input word_t seed);
    cfg_we <= 1'b1;
    cfg_data <= seed;
    @(posedge clk);
    cfg_we <= 1'b0;
    gen_state = seed;
  endtask

  task automatic test_reset_seed();
    request_draw(32'd1);
    request_draw(32'hFFFF_FFFF);
    request_draw(32'd2);
    request_draw(32'h8000_0000);
    request_draw(32'h5555_5555);
    request_draw(32'hAAAA_AAAA);
  endtask

  task automatic test_seed_extremes();
    wait_for_draws();
    load_seed(ALL_ONES);
    request_draw(32'hFFFF_FFFF);
    request_draw(32'd7);
    wait_for_draws();
    load_seed(word_t'(1));
    request_draw(32'd1);
    request_draw(32'h0001_0000);
    wait_for_draws();
    load_seed(word_t'(1) << (xud_pkg::WORD_W - 1));
    request_draw(32'd3);
    request_draw(32'hFFFF_FFFE);
  endtask

  task automatic test_rejection_edges();
    bound_t probe_bounds[3];
    word_t limit;
    probe_bounds[0] = 32'hFFFF_FFFF;
    probe_bounds[1] = 32'h8000_0001;
    probe_bounds[2] = bound_t'($urandom_range(2, 32'hFFFF));
    foreach (probe_bounds[i]) begin
      limit = reject_limit(probe_bounds[i]);
      // first word lands exactly on the limit: rejected
      wait_for_draws();
      load_seed(rewind(limit));
      request_draw(probe_bounds[i]);
      // first word just below the limit: accepted
      wait_for_draws();
      load_seed(rewind(limit - 1));
      request_draw(probe_bounds[i]);
      wait_for_draws();
      load_seed(rewind(ALL_ONES));
      request_draw(probe_bounds[i]);
    end
  endtask

  task automatic test_random_draws();
    for (int phase = 0; phase < 7; phase++) begin
      wait_for_draws();
      pace_on = (phase != 3);
      if (phase > 0) load_seed(random_seed());
      for (int i = 0; i < 250; i++) begin
        if ($urandom_range(0, 99) == 0) wait_for_draws();
        request_draw(random_bound());
      end
    end
    pace_on = 1'b1;
  endtask

  always @(posedge clk) begin
    if (!pace_on) begin
      stall_left = 0;
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
    end else if ($urandom_range(0, 3) == 0) begin
      stall_left = pick_gap();
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    draw_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_draws.size() == 0) begin
        note_fault($sformatf("unexpected transaction: value=%h raw_word=%h",
                             out_value, out_raw_word));
      end else begin
        want = pending_draws.pop_front();
        if (out_value !== want.value || out_raw_word !== want.raw_word) begin
          note_fault($sformatf("mismatch: value exp %h got %h, raw_word exp %h got %h",
                               want.value, out_value, want.raw_word, out_raw_word));
        end
      end
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_seed();
    test_seed_extremes();
    test_rejection_edges();
    test_random_draws();
    wait_for_draws();
    repeat (150) @(posedge clk);
    if (fault_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
